/* src/ecve_pkg.sv */
// Shared types and constants for the encoder count velocity estimator.
`default_nettype none
package ecve_pkg;

  localparam int unsigned ACC_W     = 96;
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned DIV_STEPS = 96;
  localparam int unsigned CNT_W     = 7;

  localparam logic [31:0] UPC_RST     = 32'd65536;
  localparam logic [31:0] OSC_RST     = 32'd50000000;
  localparam logic [31:0] TIMEOUT_RST = 32'd5000000;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic [48:0]        CAP49 = 49'h1_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_UPC     = 2'd0,
    REG_OSC     = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic        go;
    mdu_op_t     op;
    logic [63:0] opa;
    logic [31:0] opb;
  } mdu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

  typedef struct packed {
    logic [31:0] time_now;
    logic [31:0] count_word;
    logic [31:0] count_time;
    logic [31:0] index_word;
    logic        reset_request;
    logic        index_enable;
  } in_t;

  typedef struct packed {
    logic signed [31:0] ext_count;
    logic signed [31:0] net_count;
    logic signed [47:0] position;
    logic signed [47:0] position_interp;
    logic signed [47:0] velocity;
    logic               index_enable_next;
  } out_t;

endpackage
`default_nettype wire

/* src/ecve_mdu.sv */
// Shared serial multiply and divide unit: shift-add multiply, restoring divide.
`default_nettype none
module ecve_mdu
  import ecve_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mdu_cmd_t         cmd,
  output mdu_sts_t              sts,
  output logic [ACC_W-1:0]      acc
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  mdu_op_t          op_r;
  logic [ACC_W-1:0] acc_r;
  logic [63:0]      mcand_r;
  logic [31:0]      mplier_r;
  logic [31:0]      dvsr_r;
  logic [32:0]      rem_r;

  logic [64:0]      sum;
  logic [32:0]      shifted;
  logic [33:0]      diff;

  assign sum     = {1'b0, acc_r[ACC_W-1:32]} + {1'b0, mcand_r};
  assign shifted = {rem_r[31:0], acc_r[ACC_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= MDU_MUL;
    end else begin
      done_r <= !cmd.go && busy_r && (cnt_r == '0);
      if (cmd.go) begin
        busy_r <= 1'b1;
        op_r   <= cmd.op;
        cnt_r  <= (cmd.op == MDU_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      if (cmd.op == MDU_MUL) begin
        acc_r    <= '0;
        mcand_r  <= cmd.opa;
        mplier_r <= cmd.opb;
      end else begin
        dvsr_r <= cmd.opb;
        rem_r  <= '0;
      end
    end else if (busy_r) begin
      case (op_r)
        MDU_MUL: begin
          if (mplier_r[0]) acc_r <= {sum, acc_r[31:1]};
          else             acc_r <= {1'b0, acc_r[ACC_W-1:1]};
          mplier_r <= {1'b0, mplier_r[31:1]};
        end
        MDU_DIV: begin
          if (!diff[33]) begin
            rem_r <= diff[32:0];
            acc_r <= {acc_r[ACC_W-2:0], 1'b1};
          end else begin
            rem_r <= shifted;
            acc_r <= {acc_r[ACC_W-2:0], 1'b0};
          end
        end
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign acc = acc_r;

endmodule
`default_nettype wire

/* src/encoder_count_velocity_estimator.sv */
// Top level: register port, sample sequencer and result register of the estimator.
//
//  channel | ports                        | transfer
//  in      | in_valid, in_ready, in_data  | in_valid & in_ready
//  out     | out_valid, out_ready, out_data | out_valid & out_ready
//  cfg     | cfg_psel .. cfg_pready       | psel & penable & pwrite & pready
//
// One sample holds the sequencer while the serial multiply/divide unit works through it:
// one to six multiplies and divides per sample, each occupying a state until it is done.
// in_ready is high only while the sequencer is idle; one result waits in the output
// register and a held result stalls the sequencer. Reset is synchronous and restores
// the register and tracking state.
`default_nettype none
module encoder_count_velocity_estimator
  import ecve_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_VM1, S_VM2, S_VDIV, S_EM, S_EDIV, S_PM, S_IM, S_IDIV, S_OUT
  } state_t;

  function automatic logic [31:0] widen(input logic [31:0] base, input logic [31:0] word);
    logic [31:0] d;
    d = (word << 1) - (base << 1);
    return base + {d[31], d[31:1]};
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic signed [47:0] sat_q(input logic [48:0] q, input logic neg);
    if (neg) return (q[48] | q[47]) ? MIN48 : $signed(48'd0 - q[47:0]);
    else     return (q[48] | q[47]) ? MAX48 : $signed(q[47:0]);
  endfunction

  state_t             state_r;
  logic [31:0]        upc_r, osc_r, timeout_r;
  logic               first_r;
  logic [31:0]        exp_r, ec_r, et_r, iref_r;
  logic [1:0]         events_r;
  logic signed [47:0] vel_r;
  logic [31:0]        dt_r, dt2_r, raw_r, net_r;
  logic               dneg_r, ien_r;
  logic signed [47:0] pos_r;
  logic signed [49:0] interp_r;
  logic               out_valid_r;
  out_t               out_r;
  logic               go_r;
  mdu_op_t            op_r;
  logic [63:0]        opa_r;
  logic [31:0]        opb_r;

  mdu_cmd_t           cmd;
  mdu_sts_t           sts;
  logic [ACC_W-1:0]   acc;

  logic               accept, wr_en;
  logic [31:0]        raw, idx, ec1, iref1, ec2, et2, dc, dt_c, dt_n, net;
  logic               rebase, cflag, iflag, ien2;
  logic [48:0]        capq;
  logic [31:0]        upc_mag;
  logic signed [47:0] est;
  logic signed [48:0] v1, v2;
  logic [47:0]        vmag;
  logic signed [49:0] pint;
  logic signed [47:0] pint_sat;

  assign cmd = '{go: go_r, op: op_r, opa: opa_r, opb: opb_r};

  ecve_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts),
    .acc   (acc)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_UPC:     cfg_prdata = upc_r;
      REG_OSC:     cfg_prdata = osc_r;
      REG_TIMEOUT: cfg_prdata = timeout_r;
      default:     cfg_prdata = '0;
    endcase
  end

  always_comb begin
    raw    = widen(exp_r, in_data.count_word);
    idx    = widen(exp_r, in_data.index_word);
    rebase = first_r | in_data.reset_request;
    cflag  = in_data.count_word[31] & ~rebase;
    iflag  = in_data.index_word[31] & ~rebase;
    ec1    = rebase ? raw : ec_r;
    iref1  = rebase ? raw : iref_r;
    ien2   = in_data.index_enable;
    if (iflag && in_data.index_enable) begin
      iref1 = idx;
      ien2  = 1'b0;
    end
    dc   = raw - ec1;
    dt_c = in_data.count_time - et_r;
    ec2  = cflag ? raw : ec1;
    et2  = cflag ? in_data.count_time : et_r;
    dt_n = in_data.time_now - et_r;
    net  = ec2 - iref1;
  end

  assign upc_mag  = abs32(upc_r);
  assign capq     = (|acc[ACC_W-1:48]) ? CAP49 : {1'b0, acc[47:0]};
  assign est      = (capq[48] | capq[47]) ? MAX48 : $signed(capq[47:0]);
  assign v1       = (est < vel_r) ? 49'(est) : 49'(vel_r);
  assign v2       = (-49'(est) > v1) ? -49'(est) : v1;
  assign vmag     = vel_r[47] ? (48'd0 - vel_r) : vel_r;
  assign pint     = 50'(pos_r) + interp_r;
  assign pint_sat = (pint > 50'(MAX48)) ? MAX48 :
                    (pint < 50'(MIN48)) ? MIN48 : pint[47:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      upc_r       <= UPC_RST;
      osc_r       <= OSC_RST;
      timeout_r   <= TIMEOUT_RST;
      first_r     <= 1'b1;
      exp_r       <= '0;
      ec_r        <= '0;
      et_r        <= '0;
      iref_r      <= '0;
      events_r    <= '0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
      go_r        <= 1'b0;
      op_r        <= MDU_MUL;
      opa_r       <= '0;
      opb_r       <= '0;
      dt_r        <= '0;
      dt2_r       <= '0;
      raw_r       <= '0;
      net_r       <= '0;
      dneg_r      <= 1'b0;
      ien_r       <= 1'b0;
      pos_r       <= '0;
      interp_r    <= '0;
      out_r       <= '0;
    end else begin
      if (go_r) go_r <= 1'b0;
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (wr_en) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_UPC:     upc_r     <= cfg_pwdata;
          REG_OSC:     osc_r     <= cfg_pwdata;
          REG_TIMEOUT: timeout_r <= cfg_pwdata;
          default:     upc_r     <= upc_r;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            first_r <= 1'b0;
            exp_r   <= raw;
            ec_r    <= ec2;
            et_r    <= et2;
            iref_r  <= iref1;
            raw_r   <= raw;
            net_r   <= net;
            ien_r   <= ien2;
            dt2_r   <= in_data.time_now - et2;
            dneg_r  <= dc[31];
            go_r    <= 1'b1;
            op_r    <= MDU_MUL;
            if (cflag) begin
              dt_r <= dt_c;
              if (events_r != 2'd2) begin
                events_r <= events_r + 1'b1;
                opa_r    <= {32'd0, upc_mag};
                opb_r    <= abs32(net);
                state_r  <= S_PM;
              end else if (dt_c != '0) begin
                opa_r   <= {32'd0, abs32(dc)};
                opb_r   <= upc_mag;
                state_r <= S_VM1;
              end else begin
                opa_r   <= {32'd0, upc_mag};
                opb_r   <= abs32(net);
                state_r <= S_PM;
              end
            end else if (events_r != '0) begin
              dt_r <= dt_n;
              if (dt_n < timeout_r) begin
                if (dt_n != '0) begin
                  opa_r   <= {32'd0, upc_mag};
                  opb_r   <= osc_r;
                  state_r <= S_EM;
                end else begin
                  opa_r   <= {32'd0, upc_mag};
                  opb_r   <= abs32(net);
                  state_r <= S_PM;
                end
              end else begin
                events_r <= '0;
                vel_r    <= '0;
                opa_r    <= {32'd0, upc_mag};
                opb_r    <= abs32(net);
                state_r  <= S_PM;
              end
            end else begin
              vel_r   <= '0;
              opa_r   <= {32'd0, upc_mag};
              opb_r   <= abs32(net);
              state_r <= S_PM;
            end
          end
        end
        S_VM1: begin
          if (sts.done) begin
            go_r    <= 1'b1;
            op_r    <= MDU_MUL;
            opa_r   <= acc[63:0];
            opb_r   <= osc_r;
            state_r <= S_VM2;
          end
        end
        S_VM2: begin
          if (sts.done) begin
            go_r    <= 1'b1;
            op_r    <= MDU_DIV;
            opb_r   <= dt_r;
            state_r <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (sts.done) begin
            vel_r   <= sat_q(capq, dneg_r ^ upc_r[31]);
            go_r    <= 1'b1;
            op_r    <= MDU_MUL;
            opa_r   <= {32'd0, upc_mag};
            opb_r   <= abs32(net_r);
            state_r <= S_PM;
          end
        end
        S_EM: begin
          if (sts.done) begin
            go_r    <= 1'b1;
            op_r    <= MDU_DIV;
            opb_r   <= dt_r;
            state_r <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (sts.done) begin
            vel_r   <= v2[47:0];
            go_r    <= 1'b1;
            op_r    <= MDU_MUL;
            opa_r   <= {32'd0, upc_mag};
            opb_r   <= abs32(net_r);
            state_r <= S_PM;
          end
        end
        S_PM: begin
          if (sts.done) begin
            pos_r <= sat_q(capq, net_r[31] ^ upc_r[31]);
            if (osc_r != '0) begin
              go_r    <= 1'b1;
              op_r    <= MDU_MUL;
              opa_r   <= {16'd0, vmag};
              opb_r   <= dt2_r;
              state_r <= S_IM;
            end else begin
              interp_r <= '0;
              state_r  <= S_OUT;
            end
          end
        end
        S_IM: begin
          if (sts.done) begin
            go_r    <= 1'b1;
            op_r    <= MDU_DIV;
            opb_r   <= osc_r;
            state_r <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (sts.done) begin
            interp_r <= vel_r[47] ? (50'd0 - {1'b0, capq}) : {1'b0, capq};
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.ext_count         <= raw_r;
            out_r.net_count         <= net_r;
            out_r.position          <= pos_r;
            out_r.position_interp   <= pint_sat;
            out_r.velocity          <= vel_r;
            out_r.index_enable_next <= ien_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/tb_encoder_count_velocity_estimator.sv */
// Testbench for the encoder count velocity estimator: directed and random samples.
`timescale 1ns / 100ps
module tb_encoder_count_velocity_estimator;
  import ecve_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  encoder_count_velocity_estimator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor copy of registers and tracking state
  logic [31:0] scale_q16;
  logic [31:0] tick_hz;
  logic [31:0] stop_ticks;
  bit          rebase_pending;
  logic [31:0] wide_count;
  logic [31:0] last_edge_count;
  logic [31:0] last_edge_time;
  logic [31:0] index_ref;
  int          edge_events;
  longint      vel_est;

  out_t        expected_samples[$];
  int          errors;
  int          samples_sent;
  int          samples_checked;
  int unsigned cycles;
  bit          quiet;
  int          hold_left;

  // stimulus generator state
  logic [30:0] enc_pos;
  logic [31:0] tick_now;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom % 100 >= 16);
    end
  end

  function automatic longint sat48(longint v);
    if (v > longint'(MAX48)) return longint'(MAX48);
    if (v < longint'(MIN48)) return longint'(MIN48);
    return v;
  endfunction

  function automatic longint mul_div(logic [63:0] a, logic [31:0] m, logic [31:0] d);
    logic [95:0] q;
    q = ({32'd0, a} * {64'd0, m}) / {64'd0, d};
    if (q >= {47'd0, CAP49}) return longint'(CAP49);
    return longint'(q[48:0]);
  endfunction

  function automatic logic [31:0] widen(logic [31:0] base, logic [31:0] word);
    logic [31:0] d;
    d = (word << 1) - (base << 1);
    return base + {d[31], d[31:1]};
  endfunction

  function automatic longint signed_scale(longint p, logic [31:0] m, logic [31:0] d);
    longint q;
    q = mul_div(p < 0 ? -p : p, m, d);
    return sat48(p < 0 ? -q : q);
  endfunction

  function automatic out_t predict_sample(in_t s);
    out_t        r;
    longint      upc;
    logic [31:0] raw;
    logic [31:0] idx;
    logic [31:0] dt;
    bit          seen_count;
    bit          seen_index;
    bit          arm;
    longint      dc;
    longint      est;
    longint      net;
    longint      pos;
    longint      interp;
    longint      q;
    longint      pint;
    upc = longint'(signed'(scale_q16));
    raw = widen(wide_count, s.count_word);
    idx = widen(wide_count, s.index_word);
    seen_count = s.count_word[31];
    seen_index = s.index_word[31];
    arm = s.index_enable;
    wide_count = raw;
    if (rebase_pending || s.reset_request) begin
      rebase_pending = 0;
      last_edge_count = raw;
      index_ref = raw;
      seen_count = 0;
      seen_index = 0;
    end
    if (seen_index && arm) begin
      index_ref = idx;
      arm = 0;
    end
    if (seen_count) begin
      dc = longint'(signed'(raw - last_edge_count));
      dt = s.count_time - last_edge_time;
      last_edge_count = raw;
      last_edge_time = s.count_time;
      if (edge_events < 2) edge_events++;
      else if (dt != 0) vel_est = signed_scale(dc * upc, tick_hz, dt);
    end else if (edge_events != 0) begin
      dt = s.time_now - last_edge_time;
      if (dt < stop_ticks) begin
        if (dt != 0) begin
          est = sat48(mul_div(upc < 0 ? -upc : upc, tick_hz, dt));
          if (est < vel_est) vel_est = est;
          if (-est > vel_est) vel_est = -est;
        end
      end else begin
        edge_events = 0;
        vel_est = 0;
      end
    end else begin
      vel_est = 0;
    end
    net = longint'(signed'(last_edge_count - index_ref));
    pos = sat48(net * upc);
    dt = s.time_now - last_edge_time;
    interp = 0;
    if (tick_hz != 0) begin
      q = mul_div(vel_est < 0 ? -vel_est : vel_est, dt, tick_hz);
      interp = vel_est < 0 ? -q : q;
    end
    pint = sat48(pos + interp);
    r.ext_count = raw;
    r.net_count = net[31:0];
    r.position = pos[47:0];
    r.position_interp = pint[47:0];
    r.velocity = vel_est[47:0];
    r.index_enable_next = arm;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
      end else begin
        out_t e;
        e = expected_samples.pop_front();
        samples_checked++;
        if (out_data.ext_count !== e.ext_count) begin
          $error("ext_count exp %0d got %0d", e.ext_count, out_data.ext_count);
          errors++;
        end
        if (out_data.net_count !== e.net_count) begin
          $error("net_count exp %0d got %0d", e.net_count, out_data.net_count);
          errors++;
        end
        if (out_data.position !== e.position) begin
          $error("position exp %0d got %0d", e.position, out_data.position);
          errors++;
        end
        if (out_data.position_interp !== e.position_interp) begin
          $error("position_interp exp %0d got %0d", e.position_interp,
                 out_data.position_interp);
          errors++;
        end
        if (out_data.velocity !== e.velocity) begin
          $error("velocity exp %0d got %0d", e.velocity, out_data.velocity);
          errors++;
        end
        if (out_data.index_enable_next !== e.index_enable_next) begin
          $error("index_enable_next exp %0b got %0b", e.index_enable_next,
                 out_data.index_enable_next);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(in_t s);
    while (!quiet && ($urandom % 100 < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_samples.push_back(predict_sample(s));
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(r) << 2;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (r)
      REG_UPC:     scale_q16 = v;
      REG_OSC:     tick_hz = v;
      REG_TIMEOUT: stop_ticks = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] upc, logic [31:0] osc, logic [31:0] tmo);
    drain();
    cfg_write(REG_UPC, upc);
    cfg_write(REG_OSC, osc);
    cfg_write(REG_TIMEOUT, tmo);
  endtask

  function automatic in_t make_sample(bit noisy);
    in_t         s;
    logic [31:0] step;
    s.time_now = $urandom;
    s.count_word = $urandom;
    s.count_time = $urandom;
    s.index_word = $urandom;
    s.reset_request = 1'($urandom_range(0, 1));
    s.index_enable = 1'($urandom_range(0, 1));
    if (noisy) return s;
    step = ($urandom % 8 == 0) ? $urandom_range(1, 40000) : $urandom_range(0, 3000);
    tick_now += step;
    s.time_now = tick_now;
    if ($urandom % 100 < 60) begin
      enc_pos += ($urandom % 50 == 0) ? 31'($urandom) : 31'($urandom_range(0, 80) - 40);
      s.count_word = {1'b1, enc_pos};
      s.count_time = tick_now - $urandom_range(0, step);
    end else begin
      s.count_word = {1'b0, enc_pos};
    end
    s.index_word = {($urandom % 10 == 0), enc_pos - 31'($urandom_range(0, 20))};
    s.reset_request = ($urandom % 100 < 3);
    s.index_enable = ($urandom % 100 < 30);
    return s;
  endfunction

  function automatic in_t build(logic [31:0] tn, logic [31:0] cw, logic [31:0] ct,
                                logic [31:0] iw, bit rr, bit ie);
    in_t s;
    s.time_now = tn;
    s.count_word = cw;
    s.count_time = ct;
    s.index_word = iw;
    s.reset_request = rr;
    s.index_enable = ie;
    return s;
  endfunction

  task automatic test_rebase();
    send_sample(build(32'd100, 32'h8000_0010, 32'd90, 32'h8000_0005, 1'b0, 1'b1));
    send_sample(build(32'd200, 32'h8000_0020, 32'd190, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd300, 32'h8000_0030, 32'd290, 32'h8000_0001, 1'b1, 1'b1));
  endtask

  task automatic test_index();
    send_sample(build(32'd400, 32'h0000_0030, 32'd0, 32'h8000_0028, 1'b0, 1'b0));
    send_sample(build(32'd500, 32'h0000_0030, 32'd0, 32'h8000_0028, 1'b0, 1'b1));
    send_sample(build(32'd600, 32'h0000_0030, 32'd0, 32'h0000_0028, 1'b0, 1'b1));
  endtask

  task automatic test_velocity();
    send_sample(build(32'd1000, 32'h8000_0040, 32'd1000, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd2000, 32'h8000_0050, 32'd2000, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd3000, 32'h8000_0060, 32'd3000, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd3500, 32'h8000_0040, 32'd3400, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd3600, 32'h8000_0045, 32'd3400, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd3400, 32'h0000_0045, 32'd0, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd9000, 32'h0000_0045, 32'd0, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd90000, 32'h0000_0045, 32'd0, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_timeout();
    set_config(32'h7FFF_FFFF, 32'd1, 32'd0);
    send_sample(build(32'd100000, 32'h8000_0050, 32'd99000, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd100100, 32'h8000_0070, 32'd100100, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd100200, 32'h8000_0010, 32'd100200, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'd100300, 32'h0000_0010, 32'd0, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_extremes();
    set_config(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(build(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_sample(build(32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'h0, 32'hC000_0000, 32'h1, 32'hC000_0000, 1'b0, 1'b1));
    send_sample(build(32'h7, 32'hBFFF_FFFF, 32'h2, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'h9, 32'h8000_0000, 32'h3, 32'h0, 1'b0, 1'b0));
    send_sample(build(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
  endtask

  task automatic test_random_phase(int n, logic [31:0] upc, logic [31:0] osc,
                                   logic [31:0] tmo);
    set_config(upc, osc, tmo);
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 2) && (k < n / 2 + 60);
      send_sample(make_sample($urandom % 10 == 0));
    end
    quiet = 0;
  endtask

  task automatic test_backpressure();
    hold_left = 3000;
    for (int k = 0; k < 20; k++) send_sample(make_sample(1'b0));
    drain();
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cycles = 0;
    errors = 0;
    samples_sent = 0;
    samples_checked = 0;
    quiet = 0;
    hold_left = 0;
    enc_pos = '0;
    tick_now = '0;
    scale_q16 = UPC_RST;
    tick_hz = OSC_RST;
    stop_ticks = TIMEOUT_RST;
    rebase_pending = 1;
    wide_count = '0;
    last_edge_count = '0;
    last_edge_time = '0;
    index_ref = '0;
    edge_events = 0;
    vel_est = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rebase();
    test_index();
    test_velocity();
    test_timeout();
    test_extremes();
    test_random_phase(400, UPC_RST, OSC_RST, TIMEOUT_RST);
    test_random_phase(380, 32'h7FFF_FFFF, 32'd1, 32'd0);
    test_random_phase(380, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_phase(380, $urandom, $urandom_range(1000, 2000000), $urandom_range(0, 20000));
    test_backpressure();
    test_random_phase(370, $urandom, $urandom | 32'd1, $urandom);

    drain();
    repeat (400) @(posedge clk);
    $display("Ran %0d samples over default, extreme and random register values, %0d compared.",
             samples_sent, samples_checked);
    $display("Covered rebase, index capture, velocity decay, timeout and back-pressure.");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
